FILE: hw/rtl/tcprc_pkg.sv
// Shared types, codes and helpers of the Reno congestion table.
`default_nettype none
package tcprc_pkg;

   localparam int unsigned WORD_WIDTH      = 32;
   localparam int unsigned MSS_WIDTH       = 16;
   localparam int unsigned CONN_WIDTH      = 2;
   localparam int unsigned OP_WIDTH        = 2;
   localparam int unsigned DUP_WIDTH       = 2;
   localparam int unsigned CSR_INDEX_WIDTH = 8;

   localparam logic [OP_WIDTH-1:0] OP_OPEN    = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_ACK     = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_SENT    = 2'd2;
   localparam logic [OP_WIDTH-1:0] OP_TIMEOUT = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEGMENT_SIZE      = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INITIAL_THRESHOLD = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIMEOUT_MIN       = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIMEOUT_MAX       = 8'd3;

   localparam logic [MSS_WIDTH-1:0]  SEGMENT_SIZE_RESET      = 16'd536;
   localparam logic [WORD_WIDTH-1:0] INITIAL_THRESHOLD_RESET = 32'd65535;
   localparam logic [WORD_WIDTH-1:0] TIMEOUT_MIN_RESET       = 32'd10000000;
   localparam logic [WORD_WIDTH-1:0] TIMEOUT_MAX_RESET       = 32'd80000000;

   localparam logic [DUP_WIDTH-1:0] DUP_LIMIT = 2'd3;

   typedef struct packed {
      logic [MSS_WIDTH-1:0]  segment_size;
      logic [WORD_WIDTH-1:0] initial_threshold;
      logic [WORD_WIDTH-1:0] timeout_min;
      logic [WORD_WIDTH-1:0] timeout_max;
   } cfg_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] cwnd;
      logic [WORD_WIDTH-1:0] ssthresh;
      logic [WORD_WIDTH-1:0] flight;
      logic [WORD_WIDTH-1:0] last_ack;
      logic [DUP_WIDTH-1:0]  dup_count;
      logic [WORD_WIDTH-1:0] rto;
   } entry_type;

   typedef struct packed {
      entry_type entry;
      logic      fast_retransmit;
      logic      need_div;
   } upd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Unsigned add that sticks at all ones instead of wrapping.
   function automatic logic [WORD_WIDTH-1:0] sat_add32(input logic [WORD_WIDTH-1:0] a,
                                                       input logic [WORD_WIDTH-1:0] b);
      logic [WORD_WIDTH:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[WORD_WIDTH] ? '1 : sum[WORD_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/tcprc_conn_mem.sv
// Per-connection state memory with registered read and per-entry valid bits.
`default_nettype none
module tcprc_conn_mem #(
   parameter int unsigned DEPTH = 4,
   parameter int unsigned AW    = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rd_en,
   input  wire logic [AW-1:0]         rd_addr,
   output tcprc_pkg::entry_type       rd_entry,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire tcprc_pkg::entry_type  wr_entry
);
   import tcprc_pkg::*;

   entry_type        mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   entry_type        rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // An entry never written since reset reads as all zeros.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("state memory read and written in the same cycle");

   a_write_marks_valid : assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(wr_addr)])
      else $error("written entry not marked valid");

endmodule
`default_nettype wire

FILE: hw/rtl/tcprc_div.sv
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
`default_nettype none
module tcprc_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [31:0]           dividend,
   input  wire logic [31:0]           divisor,
   output tcprc_pkg::div_status_type  status,
   output logic [31:0]                quotient
);
   import tcprc_pkg::*;

   localparam int unsigned CNT_W = $clog2(WORD_WIDTH);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_WIDTH - 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [WORD_WIDTH-1:0] rem_ff;
   logic [WORD_WIDTH-1:0] quo_ff;
   logic [WORD_WIDTH-1:0] den_ff;
   logic [WORD_WIDTH:0]   trial;
   logic [WORD_WIDTH:0]   diff;
   logic [WORD_WIDTH-1:0] rem_in;
   logic [WORD_WIDTH-1:0] quo_in;

   always_comb begin
      trial = {rem_ff, quo_ff[WORD_WIDTH-1]};
      diff  = trial - {1'b0, den_ff};
      if (!diff[WORD_WIDTH]) begin
         rem_in = diff[WORD_WIDTH-1:0];
         quo_in = {quo_ff[WORD_WIDTH-2:0], 1'b1};
      end else begin
         rem_in = trial[WORD_WIDTH-1:0];
         quo_in = {quo_ff[WORD_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_divisor_nonzero : assert property (@(posedge clock) disable iff (reset)
      start |-> divisor != '0)
      else $error("divider started with a zero divisor");

endmodule
`default_nettype wire

FILE: hw/rtl/tcprc_update.sv
// Next-state logic of one connection entry for each operation.
`default_nettype none
module tcprc_update (
   input  wire logic [1:0]   opcode,
   input  wire logic [31:0]  ack_number,
   input  wire logic [15:0]  byte_count,
   input  wire logic [15:0]  peer_segment_size,
   input  wire tcprc_pkg::cfg_type   cfg,
   input  wire tcprc_pkg::entry_type cur,
   output tcprc_pkg::upd_type   upd
);
   import tcprc_pkg::*;

   logic [WORD_WIDTH-1:0] mss;
   logic [WORD_WIDTH-1:0] two_mss;
   logic [WORD_WIDTH-1:0] three_mss;
   logic [WORD_WIDTH-1:0] half_flight;
   logic [WORD_WIDTH-1:0] halved_floor;
   logic [WORD_WIDTH-1:0] acked;
   logic [DUP_WIDTH-1:0]  dup_next;
   logic [WORD_WIDTH:0]   grown;
   logic [WORD_WIDTH:0]   rto_doubled;

   always_comb begin
      mss          = WORD_WIDTH'(cfg.segment_size);
      two_mss      = WORD_WIDTH'({cfg.segment_size, 1'b0});
      three_mss    = WORD_WIDTH'({1'b0, cfg.segment_size, 1'b0} + 18'(cfg.segment_size));
      half_flight  = cur.flight >> 1;
      halved_floor = (half_flight > two_mss) ? half_flight : two_mss;
      acked        = ack_number - cur.last_ack;
      dup_next     = cur.dup_count + 1'b1;
      grown        = {1'b0, cur.cwnd} + {1'b0, mss};
      rto_doubled  = {cur.rto, 1'b0};

      upd.entry           = cur;
      upd.fast_retransmit = 1'b0;
      upd.need_div        = 1'b0;

      case (opcode)
         OP_OPEN: begin
            upd.entry.cwnd = (peer_segment_size != '0 && peer_segment_size < cfg.segment_size)
                             ? WORD_WIDTH'(peer_segment_size) : mss;
            upd.entry.ssthresh  = cfg.initial_threshold;
            upd.entry.flight    = '0;
            upd.entry.last_ack  = '0;
            upd.entry.dup_count = '0;
            upd.entry.rto       = cfg.timeout_min;
         end
         OP_ACK: begin
            if (acked == '0) begin
               if (dup_next == DUP_LIMIT) begin
                  upd.entry.dup_count = '0;
                  upd.entry.ssthresh  = halved_floor;
                  upd.entry.cwnd      = sat_add32(halved_floor, three_mss);
                  upd.fast_retransmit = 1'b1;
               end else begin
                  upd.entry.dup_count = dup_next;
               end
            end else begin
               upd.entry.dup_count = '0;
               upd.entry.flight    = (cur.flight >= acked) ? cur.flight - acked : '0;
               upd.entry.last_ack  = ack_number;
               if (cur.cwnd < cur.ssthresh) begin
                  upd.entry.cwnd = (grown > {1'b0, cur.ssthresh})
                                   ? cur.ssthresh : grown[WORD_WIDTH-1:0];
               end else begin
                  // Congestion avoidance: the window is finished by the divider.
                  upd.need_div = 1'b1;
               end
            end
         end
         OP_SENT: begin
            upd.entry.flight = sat_add32(cur.flight, WORD_WIDTH'(byte_count));
         end
         OP_TIMEOUT: begin
            upd.entry.rto       = (rto_doubled > {1'b0, cfg.timeout_max})
                                  ? cfg.timeout_max : rto_doubled[WORD_WIDTH-1:0];
            upd.entry.ssthresh  = halved_floor;
            upd.entry.cwnd      = mss;
            upd.entry.flight    = '0;
            upd.entry.dup_count = '0;
         end
         default: begin
            upd.entry = cur;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: hw/rtl/tcp_reno_congestion_control.sv
// Top level of the per-connection TCP Reno congestion control table.
// Each request transaction names a connection and an operation (open, ack received, bytes
// sent, retransmission timeout); the block reads that connection's entry from an internal
// state memory, updates it and writes it back, and returns one response transaction with
// the connection's window, threshold, flight size, send allowance, fast retransmit flag and
// retransmission timeout after the update. A connection index at or above CONNECTIONS
// changes nothing and returns all zeros. Requests are processed one at a time: for an open,
// sent, timeout, duplicate ack or slow start ack the request passes from the execute state
// to the write-back state, where the response register is loaded; an ack in congestion
// avoidance passes through a divide state between the two, because the window increment
// MSS*MSS/cwnd goes through a 32-step restoring divider. The memory read is registered and
// the entry is written back in the last cycle of the request, so a following request to
// the same connection always sees the updated entry. A new request may be accepted while
// the previous response still waits for rsp_ready; it then waits in its final cycle until
// the response register frees up. Entries read as zero until first written after reset,
// so no clearing pass is needed. The configuration registers are written through the csr_
// channel, which is always ready, and should only be written while no request is in
// progress.
`default_nettype none
module tcp_reno_congestion_control #(
   parameter int unsigned CONNECTIONS = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [1:0]   req_opcode,
   input  wire logic [1:0]   req_connection,
   input  wire logic [31:0]  req_ack_number,
   input  wire logic [15:0]  req_byte_count,
   input  wire logic [15:0]  req_peer_segment_size,

   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [31:0]       rsp_window,
   output logic [31:0]       rsp_threshold,
   output logic [31:0]       rsp_in_flight,
   output logic [31:0]       rsp_send_allowance,
   output logic              rsp_fast_retransmit,
   output logic [31:0]       rsp_timeout_value,

   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_index,
   input  wire logic [31:0]  csr_data
);
   import tcprc_pkg::*;

   localparam int unsigned AW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   logic [1:0]            state_ff;
   cfg_type               cfg_ff;

   logic [OP_WIDTH-1:0]   op_ff;
   logic [CONN_WIDTH-1:0] conn_ff;
   logic [31:0]           ack_ff;
   logic [15:0]           bytes_ff;
   logic [15:0]           peer_ff;
   logic                  in_range_ff;

   entry_type             new_entry_ff;
   logic                  fr_ff;

   logic                  rsp_valid_ff;
   logic [31:0]           rsp_window_ff;
   logic [31:0]           rsp_threshold_ff;
   logic [31:0]           rsp_in_flight_ff;
   logic [31:0]           rsp_send_allowance_ff;
   logic                  rsp_fast_retransmit_ff;
   logic [31:0]           rsp_timeout_value_ff;

   logic                  req_fire;
   logic                  req_in_range;
   logic                  rsp_free;
   logic                  finish;
   entry_type             cur_entry;
   upd_type               upd;
   logic                  div_start;
   logic [31:0]           div_dividend;
   logic [31:0]           div_divisor;
   div_status_type        div_status;
   logic [31:0]           div_quotient;
   logic                  mem_rd_en;
   logic                  mem_wr_en;
   logic [31:0]           allowance;

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign req_in_range = 32'(req_connection) < CONNECTIONS;
   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign finish       = (state_ff == ST_WRITE) && rsp_free;
   assign csr_ready    = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.segment_size      <= SEGMENT_SIZE_RESET;
         cfg_ff.initial_threshold <= INITIAL_THRESHOLD_RESET;
         cfg_ff.timeout_min       <= TIMEOUT_MIN_RESET;
         cfg_ff.timeout_max       <= TIMEOUT_MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SEGMENT_SIZE:      cfg_ff.segment_size      <= csr_data[15:0];
            CSR_INITIAL_THRESHOLD: cfg_ff.initial_threshold <= csr_data;
            CSR_TIMEOUT_MIN:       cfg_ff.timeout_min       <= csr_data;
            CSR_TIMEOUT_MAX:       cfg_ff.timeout_max       <= csr_data;
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // The entry is read at the acceptance edge and is available in the execute cycle.
   assign mem_rd_en = req_fire && req_in_range;
   assign mem_wr_en = finish && in_range_ff;

   tcprc_conn_mem #(
      .DEPTH (CONNECTIONS),
      .AW    (AW)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (mem_rd_en),
      .rd_addr  (AW'(req_connection)),
      .rd_entry (cur_entry),
      .wr_en    (mem_wr_en),
      .wr_addr  (AW'(conn_ff)),
      .wr_entry (new_entry_ff)
   );

   tcprc_update u_update (
      .opcode            (op_ff),
      .ack_number        (ack_ff),
      .byte_count        (bytes_ff),
      .peer_segment_size (peer_ff),
      .cfg               (cfg_ff),
      .cur               (cur_entry),
      .upd               (upd)
   );

   // Congestion avoidance increment: MSS squared over the window, a zero window
   // dividing as one.
   assign div_start    = (state_ff == ST_EXEC) && upd.need_div && in_range_ff;
   assign div_dividend = 32'(cfg_ff.segment_size) * 32'(cfg_ff.segment_size);
   assign div_divisor  = (cur_entry.cwnd == '0) ? 32'd1 : cur_entry.cwnd;

   tcprc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               state_ff <= div_start ? ST_DIV : ST_WRITE;
            end
            ST_DIV: begin
               if (div_status.done) begin
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign allowance = (new_entry_ff.cwnd > new_entry_ff.flight)
                      ? new_entry_ff.cwnd - new_entry_ff.flight : '0;

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff       <= req_opcode;
         conn_ff     <= req_connection;
         ack_ff      <= req_ack_number;
         bytes_ff    <= req_byte_count;
         peer_ff     <= req_peer_segment_size;
         in_range_ff <= req_in_range;
      end
      if (state_ff == ST_EXEC) begin
         new_entry_ff <= upd.entry;
         fr_ff        <= upd.fast_retransmit;
      end
      if ((state_ff == ST_DIV) && div_status.done) begin
         new_entry_ff.cwnd <= sat_add32(cur_entry.cwnd, div_quotient);
      end
      if (finish) begin
         rsp_window_ff          <= in_range_ff ? new_entry_ff.cwnd     : '0;
         rsp_threshold_ff       <= in_range_ff ? new_entry_ff.ssthresh : '0;
         rsp_in_flight_ff       <= in_range_ff ? new_entry_ff.flight   : '0;
         rsp_send_allowance_ff  <= in_range_ff ? allowance             : '0;
         rsp_fast_retransmit_ff <= in_range_ff && fr_ff;
         rsp_timeout_value_ff   <= in_range_ff ? new_entry_ff.rto      : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_window          = rsp_window_ff;
   assign rsp_threshold       = rsp_threshold_ff;
   assign rsp_in_flight       = rsp_in_flight_ff;
   assign rsp_send_allowance  = rsp_send_allowance_ff;
   assign rsp_fast_retransmit = rsp_fast_retransmit_ff;
   assign rsp_timeout_value   = rsp_timeout_value_ff;

   a_rsp_from_write : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_WRITE)
      else $error("response raised outside the write-back cycle");

   a_div_covers_wait : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_status.busy || div_status.done))
      else $error("waiting on a divider that is not running");

   a_fr_only_on_ack : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WRITE) && fr_ff) |-> (op_ff == OP_ACK))
      else $error("fast retransmit flagged for an operation other than ack");

endmodule
`default_nettype wire
